// ===== rtl/mlfq_pkg.sv =====
// Shared constants, types and slot addressing for the feedback queue scheduler.
package mlfq_pkg;

    localparam int LEVELS      = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOTS       = LEVELS * QUEUE_DEPTH;
    localparam int AW          = $clog2(SLOTS);
    localparam int HW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int LW          = 2;
    localparam int IDW         = 8;
    localparam int WKW         = 17;
    localparam int TWW         = 16;
    localparam int WTW         = 16;
    localparam int SLW         = 10;
    localparam int THW         = 16;
    localparam int PCW         = 6;
    localparam int TLW         = 3;
    localparam int CFG_IW      = 3;
    localparam int CFG_DW      = 16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [CFG_IW-1:0] REG_SLICE0 = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SLICE1 = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SLICE2 = 3'd2;
    localparam logic [CFG_IW-1:0] REG_THRESH = 3'd3;

    localparam logic [SLW-1:0] SLICE0_RST = 10'd10;
    localparam logic [SLW-1:0] SLICE1_RST = 10'd20;
    localparam logic [SLW-1:0] SLICE2_RST = 10'd40;
    localparam logic [THW-1:0] THRESH_RST = 16'd50;

    typedef struct packed {
        logic [IDW-1:0]        id;
        logic signed [WKW-1:0] work;
        logic [WTW-1:0]        wait_time;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // memory slot of entry k behind the head of a level
    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lvl,
                                                input logic [HW-1:0] head,
                                                input logic [CW-1:0] k);
        logic [CW:0] sum;
        logic [CW:0] off;
        sum = (CW+1)'(head) + (CW+1)'(k);
        off = (sum >= (CW+1)'(QUEUE_DEPTH)) ? sum - (CW+1)'(QUEUE_DEPTH) : sum;
        return AW'(lvl) * AW'(QUEUE_DEPTH) + AW'(off);
    endfunction

    function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] head);
        logic [HW:0] nx;
        nx = (HW+1)'(head) + (HW+1)'(1);
        return (nx == (HW+1)'(QUEUE_DEPTH)) ? '0 : nx[HW-1:0];
    endfunction

endpackage

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// Top level: three-level feedback queue scheduler with a sequenced task store.
//
//  channel | dir | handshake                  | payload
//  in      | in  | i_in_valid / o_in_stall    | i_op, i_task_id, i_task_work, i_task_level
//  out     | out | o_out_valid / i_out_stall  | o_status .. o_promoted_count
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Add goes from idle straight to the finish state. Dispatch reads the head, then
// ages each task in levels 1..2 with a read state and a write state, then scans them
// for promotion the same way, walking the task store one entry at a time.
// Reset is synchronous and empties all queues; store contents are not cleared.
// o_in_stall is high while an item is in work or its result cannot be loaded.
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [IDW-1:0]        i_task_id,
    input  logic [TWW-1:0]        i_task_work,
    input  logic [TLW-1:0]        i_task_level,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [IDW-1:0]        o_ran_id,
    output logic [LW-1:0]         o_ran_level,
    output logic [SLW-1:0]        o_slice_used,
    output logic signed [WKW-1:0] o_work_left,
    output logic                  o_finished,
    output logic [LW-1:0]         o_new_level,
    output logic [PCW-1:0]        o_promoted_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IW-1:0]     i_cfg_index,
    input  logic [CFG_DW-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_AGE_RD, S_AGE_WR, S_PRO_RD, S_PRO_WR, S_FIN
    } t_state;

    t_state r_state, n_state;

    logic [HW-1:0] r_head [LEVELS];
    logic [HW-1:0] n_head [LEVELS];
    logic [CW-1:0] r_count [LEVELS];
    logic [CW-1:0] n_count [LEVELS];

    logic [SLW-1:0] r_slice0, r_slice1, r_slice2;
    logic [THW-1:0] r_thresh;

    logic [1:0]            r_status, n_status;
    logic [IDW-1:0]        r_rid, n_rid;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic [SLW-1:0]        r_slice, n_slice;
    logic signed [WKW-1:0] r_left, n_left;
    logic                  r_done, n_done;
    logic [LW-1:0]         r_newl, n_newl;
    logic [PCW-1:0]        r_promoted, n_promoted;
    logic [LW-1:0]         r_i, n_i;
    logic [CW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_n, n_n;
    logic [CW-1:0]         r_kept, n_kept;

    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_o_status;
    logic [IDW-1:0]        r_o_rid;
    logic [LW-1:0]         r_o_lvl;
    logic [SLW-1:0]        r_o_slice;
    logic signed [WKW-1:0] r_o_left;
    logic                  r_o_done;
    logic [LW-1:0]         r_o_newl;
    logic [PCW-1:0]        r_o_promoted;
    logic                  load_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, rd;

    mlfq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    always_comb begin
        logic [LW-1:0]         fl;
        logic                  found;
        logic [LW-1:0]         lv;
        logic [SLW-1:0]        sl;
        logic signed [WKW-1:0] lf;
        logic                  dn;
        logic [LW-1:0]         nl;
        logic [WTW:0]          ws;
        logic [LW-1:0]         up;

        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_status   = r_status;
        n_rid      = r_rid;
        n_lvl      = r_lvl;
        n_slice    = r_slice;
        n_left     = r_left;
        n_done     = r_done;
        n_newl     = r_newl;
        n_promoted = r_promoted;
        n_i        = r_i;
        n_k        = r_k;
        n_n        = r_n;
        n_kept     = r_kept;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;
        load_out   = 1'b0;
        n_out_valid = r_out_valid & i_out_stall;

        fl    = '0;
        found = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                fl    = LW'(l);
                found = 1'b1;
            end
        end

        lv = i_task_level[LW-1:0];
        sl = (r_lvl == LW'(0)) ? r_slice0 : (r_lvl == LW'(1)) ? r_slice1 : r_slice2;
        lf = rd.work - $signed({{(WKW-SLW){1'b0}}, sl});
        dn = (lf <= $signed(WKW'(0)));
        nl = r_lvl;
        ws = {1'b0, rd.wait_time} + (WTW+1)'(r_slice);
        up = r_i - LW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rid      = '0;
                    n_lvl      = '0;
                    n_slice    = '0;
                    n_left     = '0;
                    n_done     = 1'b0;
                    n_newl     = '0;
                    n_promoted = '0;
                    n_status   = ST_OK;
                    n_state    = S_FIN;
                    if (i_op == OP_ADD) begin
                        if (i_task_level >= TLW'(LEVELS)) begin
                            n_status = ST_BAD_LEVEL;
                        end else if (r_count[lv] >= CW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_addr(lv, r_head[lv], r_count[lv]);
                            ram_wdata = '{id: i_task_id,
                                          work: $signed({1'b0, i_task_work}),
                                          wait_time: '0};
                            n_count[lv] = r_count[lv] + CW'(1);
                        end
                    end else if (!found) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_lvl     = fl;
                        ram_raddr = slot_addr(fl, r_head[fl], '0);
                        n_state   = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_rid   = rd.id;
                n_slice = sl;
                n_left  = lf;
                n_done  = dn;
                n_head[r_lvl]  = head_inc(r_head[r_lvl]);
                n_count[r_lvl] = r_count[r_lvl] - CW'(1);
                if (!dn) begin
                    if (int'(r_lvl) + 1 < LEVELS) begin
                        nl = r_lvl + LW'(1);
                    end
                    if (n_count[nl] >= CW'(QUEUE_DEPTH)) begin
                        nl = r_lvl;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(nl, n_head[nl], n_count[nl]);
                    ram_wdata = '{id: rd.id, work: lf, wait_time: rd.wait_time};
                    n_count[nl] = n_count[nl] + CW'(1);
                end
                n_newl  = dn ? '0 : nl;
                n_i     = LW'(1);
                n_k     = '0;
                n_state = S_AGE_RD;
            end
            S_AGE_RD: begin
                if (r_k >= r_count[r_i]) begin
                    n_k = '0;
                    if (r_i == LW'(LEVELS - 1)) begin
                        n_i     = LW'(1);
                        n_n     = r_count[1];
                        n_kept  = '0;
                        n_state = S_PRO_RD;
                    end else begin
                        n_i = r_i + LW'(1);
                    end
                end else begin
                    ram_raddr = slot_addr(r_i, r_head[r_i], r_k);
                    n_state   = S_AGE_WR;
                end
            end
            S_AGE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(r_i, r_head[r_i], r_k);
                ram_wdata = '{id: rd.id, work: rd.work,
                              wait_time: ws[WTW] ? '1 : ws[WTW-1:0]};
                n_k       = r_k + CW'(1);
                n_state   = S_AGE_RD;
            end
            S_PRO_RD: begin
                if (r_k >= r_n) begin
                    n_count[r_i] = r_kept;
                    n_k          = '0;
                    n_kept       = '0;
                    if (r_i == LW'(LEVELS - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_i = r_i + LW'(1);
                        n_n = r_count[r_i + LW'(1)];
                    end
                end else begin
                    ram_raddr = slot_addr(r_i, r_head[r_i], r_k);
                    n_state   = S_PRO_WR;
                end
            end
            S_PRO_WR: begin
                ram_we = 1'b1;
                if (rd.wait_time >= r_thresh && r_count[up] < CW'(QUEUE_DEPTH)) begin
                    ram_waddr   = slot_addr(up, r_head[up], r_count[up]);
                    ram_wdata   = '{id: rd.id, work: rd.work, wait_time: '0};
                    n_count[up] = r_count[up] + CW'(1);
                    n_promoted  = r_promoted + PCW'(1);
                end else begin
                    // kept tasks compact toward the head in queue order
                    ram_waddr = slot_addr(r_i, r_head[r_i], r_kept);
                    ram_wdata = rd;
                    n_kept    = r_kept + CW'(1);
                end
                n_k     = r_k + CW'(1);
                n_state = S_PRO_RD;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_slice0    <= SLICE0_RST;
            r_slice1    <= SLICE1_RST;
            r_slice2    <= SLICE2_RST;
            r_thresh    <= THRESH_RST;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_count     <= n_count;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SLICE0: r_slice0 <= i_cfg_data[SLW-1:0];
                    REG_SLICE1: r_slice1 <= i_cfg_data[SLW-1:0];
                    REG_SLICE2: r_slice2 <= i_cfg_data[SLW-1:0];
                    REG_THRESH: r_thresh <= i_cfg_data[THW-1:0];
                    default: ;
                endcase
            end
        end
        r_status   <= n_status;
        r_rid      <= n_rid;
        r_lvl      <= n_lvl;
        r_slice    <= n_slice;
        r_left     <= n_left;
        r_done     <= n_done;
        r_newl     <= n_newl;
        r_promoted <= n_promoted;
        r_i        <= n_i;
        r_k        <= n_k;
        r_n        <= n_n;
        r_kept     <= n_kept;
        if (load_out) begin
            r_o_status   <= r_status;
            r_o_rid      <= r_rid;
            r_o_lvl      <= r_lvl;
            r_o_slice    <= r_slice;
            r_o_left     <= r_left;
            r_o_done     <= r_done;
            r_o_newl     <= r_newl;
            r_o_promoted <= r_promoted;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_ran_id         = r_o_rid;
    assign o_ran_level      = r_o_lvl;
    assign o_slice_used     = r_o_slice;
    assign o_work_left      = r_o_left;
    assign o_finished       = r_o_done;
    assign o_new_level      = r_o_newl;
    assign o_promoted_count = r_o_promoted;

endmodule

// ===== rtl/mlfq_ram.sv =====
// Generic single write, single registered read port RAM.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb_multilevel_feedback_queue_scheduler.sv =====
// Self-checking testbench for the three-level feedback queue scheduler.
`timescale 1ns / 100ps

module tb_multilevel_feedback_queue_scheduler;
    import mlfq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [1:0]            status;
        logic [IDW-1:0]        ran_id;
        logic [LW-1:0]         ran_level;
        logic [SLW-1:0]        slice_used;
        logic signed [WKW-1:0] work_left;
        logic                  finished;
        logic [LW-1:0]         new_level;
        logic [PCW-1:0]        promoted_count;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [IDW-1:0]        i_task_id;
    logic [TWW-1:0]        i_task_work;
    logic [TLW-1:0]        i_task_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_status;
    logic [IDW-1:0]        o_ran_id;
    logic [LW-1:0]         o_ran_level;
    logic [SLW-1:0]        o_slice_used;
    logic signed [WKW-1:0] o_work_left;
    logic                  o_finished;
    logic [LW-1:0]         o_new_level;
    logic [PCW-1:0]        o_promoted_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IW-1:0]     i_cfg_index;
    logic [CFG_DW-1:0]     i_cfg_data;

    multilevel_feedback_queue_scheduler i_dut (.*);

    // scheduler shadow state
    logic [SLW-1:0]        sched_slice [LEVELS];
    logic [THW-1:0]        sched_thresh;
    logic [IDW-1:0]        q_id   [LEVELS][$];
    logic signed [WKW-1:0] q_work [LEVELS][$];
    logic [WTW-1:0]        q_wait [LEVELS][$];

    t_outcome pending_outcomes[$];
    int       mismatch_count;
    int       idle_cycles;
    bit       timed_out;
    int       burst_left;
    int       stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic t_outcome schedule_step(input logic op, input logic [IDW-1:0] id,
                                               input logic [TWW-1:0] work,
                                               input logic [TLW-1:0] lvl_in);
        t_outcome r;
        int lvl, newl, n, moved;
        logic [SLW-1:0] slice;
        logic signed [WKW-1:0] left;
        logic [IDW-1:0] rid;
        logic [WTW-1:0] rwait, k_wait;
        logic [IDW-1:0] k_id;
        logic signed [WKW-1:0] k_work;
        int w;
        r = '0;
        if (op == OP_ADD) begin
            if (lvl_in >= LEVELS) begin
                r.status = ST_BAD_LEVEL;
            end else if (q_id[lvl_in].size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                q_id[lvl_in].push_back(id);
                q_work[lvl_in].push_back(WKW'(work));
                q_wait[lvl_in].push_back('0);
            end
            return r;
        end
        lvl = LEVELS;
        for (int i = LEVELS - 1; i >= 0; i--)
            if (q_id[i].size() != 0) lvl = i;
        if (lvl == LEVELS) begin
            r.status = ST_EMPTY;
            return r;
        end
        slice = sched_slice[lvl];
        rid   = q_id[lvl].pop_front();
        left  = q_work[lvl].pop_front() - WKW'(slice);
        rwait = q_wait[lvl].pop_front();
        newl  = 0;
        if (left > 0) begin
            newl = (lvl + 1 < LEVELS) ? lvl + 1 : lvl;
            if (q_id[newl].size() >= QUEUE_DEPTH) newl = lvl;
            q_id[newl].push_back(rid);
            q_work[newl].push_back(left);
            q_wait[newl].push_back(rwait);
        end
        // only levels below the top age
        for (int i = 1; i < LEVELS; i++)
            for (int k = 0; k < q_wait[i].size(); k++) begin
                w = int'(q_wait[i][k]) + int'(slice);
                q_wait[i][k] = (w > 65535) ? 16'hFFFF : WTW'(w);
            end
        moved = 0;
        for (int i = 1; i < LEVELS; i++) begin
            n = q_id[i].size();
            // each entry is taken from the front and either moved up or put back
            for (int k = 0; k < n; k++) begin
                k_id = q_id[i].pop_front();
                k_work = q_work[i].pop_front();
                k_wait = q_wait[i].pop_front();
                if (k_wait >= sched_thresh && q_id[i-1].size() < QUEUE_DEPTH) begin
                    q_id[i-1].push_back(k_id);
                    q_work[i-1].push_back(k_work);
                    q_wait[i-1].push_back('0);
                    moved++;
                end else begin
                    q_id[i].push_back(k_id);
                    q_work[i].push_back(k_work);
                    q_wait[i].push_back(k_wait);
                end
            end
        end
        r.status         = ST_OK;
        r.ran_id         = rid;
        r.ran_level      = LW'(lvl);
        r.slice_used     = slice;
        r.work_left      = left;
        r.finished       = (left <= 0);
        r.new_level      = (left <= 0) ? '0 : LW'(newl);
        r.promoted_count = PCW'(moved);
        return r;
    endfunction

    // one beat on the input channel, with burst/gap pacing
    task automatic send_item(input logic op, input logic [IDW-1:0] id,
                             input logic [TWW-1:0] work, input logic [TLW-1:0] lvl);
        // valid is already low whenever a burst has ended
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_task_id    <= id;
        i_task_work  <= work;
        i_task_level <= lvl;
        do @(posedge i_clk); while (o_in_stall || timed_out);
        pending_outcomes.push_back(schedule_step(op, id, work, lvl));
        // valid drops only if the next call opens a gap
        if (burst_left == 0) i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SLICE0: sched_slice[0] = data[SLW-1:0];
            REG_SLICE1: sched_slice[1] = data[SLW-1:0];
            REG_SLICE2: sched_slice[2] = data[SLW-1:0];
            REG_THRESH: sched_thresh   = data[THW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int s0, input int s1, input int s2, input int th);
        wait_drained();
        write_reg(REG_SLICE0, CFG_DW'(s0));
        write_reg(REG_SLICE1, CFG_DW'(s1));
        write_reg(REG_SLICE2, CFG_DW'(s2));
        write_reg(REG_THRESH, CFG_DW'(th));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic dispatch_one();
        send_item(OP_DISPATCH, IDW'($urandom), TWW'($urandom), TLW'($urandom));
    endtask

    task automatic add_task(input int lvl, input int work);
        send_item(OP_ADD, IDW'($urandom), TWW'(work), TLW'(lvl));
    endtask

    task automatic test_directed();
        dispatch_one();                            // empty scheduler
        send_item(OP_ADD, 8'hFF, 16'hFFFF, 3'd7);  // invalid level
        send_item(OP_ADD, 8'h00, 16'h0000, 3'd3);
        send_item(OP_ADD, 8'hAA, 16'h0000, 3'd0);  // zero work finishes
        send_item(OP_ADD, 8'h55, 16'hFFFF, 3'd2);
        send_item(OP_ADD, 8'h12, 16'd25, 3'd1);
        send_item(OP_ADD, 8'hFF, 16'd5, 3'd0);
        repeat (6) dispatch_one();
    endtask

    task automatic test_full_levels();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++) add_task(2, $urandom_range(1000, 65535));
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) add_task(1, $urandom_range(30, 65535));
        repeat (40) dispatch_one();
    endtask

    task automatic test_random(input int count);
        int lvl;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 45) begin
                lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
                case ($urandom_range(0, 3))
                    0: add_task(lvl, $urandom_range(0, 60));
                    1: add_task(lvl, $urandom);
                    default: add_task(lvl, $urandom_range(0, 400));
                endcase
            end else begin
                dispatch_one();
            end
        end
    endtask

    task automatic test_pause_drain();
        wait_drained();
        test_random(20);
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_ran_id, o_ran_level, o_slice_used, o_work_left,
                   o_finished, o_new_level, o_promoted_count};
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 32'(got.status), 32'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.ran_id != want.ran_id)
                    report_mismatch("ran_id", 32'(got.ran_id), 32'(want.ran_id));
                if (got.ran_level != want.ran_level)
                    report_mismatch("ran_level", 32'(got.ran_level), 32'(want.ran_level));
                if (got.slice_used != want.slice_used)
                    report_mismatch("slice_used", 32'(got.slice_used),
                                    32'(want.slice_used));
                if (got.work_left != want.work_left)
                    report_mismatch("work_left", 32'(got.work_left), 32'(want.work_left));
                if (got.finished != want.finished)
                    report_mismatch("finished", 32'(got.finished), 32'(want.finished));
                if (got.new_level != want.new_level)
                    report_mismatch("new_level", 32'(got.new_level), 32'(want.new_level));
                if (got.promoted_count != want.promoted_count)
                    report_mismatch("promoted_count", 32'(got.promoted_count),
                                    32'(want.promoted_count));
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("multilevel_feedback_queue_scheduler verification failed");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        burst_left     = 0;
        stall_mode     = 0;
        sched_slice[0] = SLICE0_RST;
        sched_slice[1] = SLICE1_RST;
        sched_slice[2] = SLICE2_RST;
        sched_thresh   = THRESH_RST;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_op         <= OP_ADD;
        i_task_id    <= '0;
        i_task_work  <= '0;
        i_task_level <= '0;
        i_out_stall  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_levels();
        test_random(240);
        test_pause_drain();
        set_config(1, 1, 1, 0);           // one-unit slices, promote at once
        test_random(250);
        set_config(1023, 1023, 1023, 65535);
        test_directed();
        test_random(250);
        set_config(0, 0, 0, 1);           // zero slices leave work unchanged
        test_random(120);
        set_config(5, 300, 700, 200);
        test_full_levels();
        test_random(300);
        set_config(700, 15, 1000, 40000); // long waits saturate
        test_random(300);
        wait_drained();

        if (mismatch_count == 0)
            $display("multilevel_feedback_queue_scheduler verification clean");
        else
            $display("multilevel_feedback_queue_scheduler verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mlfq_pkg.sv
rtl/mlfq_ram.sv
rtl/multilevel_feedback_queue_scheduler.sv
tb/tb_multilevel_feedback_queue_scheduler.sv
